### src/command_line_tokenizer_hash_assert.svh
// Assertion macros for the tokenizer RTL.
// Depends on nothing; included by command_line_tokenizer_hash, which checks its own logic.
`ifndef COMMAND_LINE_TOKENIZER_HASH_ASSERT_SVH
`define COMMAND_LINE_TOKENIZER_HASH_ASSERT_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, checked outside reset.
`define CLTH_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tokenizer check failed");

// Next-cycle implication, checked outside reset.
`define CLTH_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tokenizer check failed");

`else

`define CLTH_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define CLTH_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

### src/clth_pkg.sv
// Shared types and constants for the command line tokenizer.
// No dependencies; used by clth_out_if, clth_cfg_if, clth_step and the top level.
package clth_pkg;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 8;
    localparam int PART_W     = 4;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_DELIMITER  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_PART_LIMIT = 1'b1;

    localparam logic [31:0]       HASH_SEED     = 32'd5381;
    localparam logic [7:0]        CHAR_CR       = 8'd13;
    localparam logic [7:0]        CHAR_LF       = 8'd10;
    localparam logic [7:0]        DELIM_RESET   = 8'd32;
    localparam logic [PART_W-1:0] LIMIT_RESET   = 4'd8;
    localparam int                HASH_SHIFT    = 5;

    typedef struct packed {
        logic [31:0]       running_hash;
        logic              in_params;
        logic [PART_W-1:0] parts_found;
        logic              part_open;
    } line_state_t;

    typedef struct packed {
        logic [7:0]        char_out;
        logic              char_kept;
        logic [PART_W-1:0] part_index;
        logic              line_done;
        logic [31:0]       name_hash;
        logic [PART_W-1:0] part_count;
    } result_t;

    localparam line_state_t LINE_CLEAR = '{
        running_hash: HASH_SEED,
        in_params:    1'b0,
        parts_found:  '0,
        part_open:    1'b0
    };

endpackage

### src/clth_in_if.sv
// Input byte channel: valid/ready with one command line byte.
// Depends on nothing.
interface clth_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_in;
    logic       line_end;

    modport source (output valid, output char_in, output line_end, input ready);
    modport sink   (input valid, input char_in, input line_end, output ready);
endinterface

### src/clth_out_if.sv
// Result channel: valid/ready with one tokenizer result.
// Depends on clth_pkg for widths.
interface clth_out_if;
    logic                       valid;
    logic                       ready;
    logic [7:0]                 char_out;
    logic                       char_kept;
    logic [clth_pkg::PART_W-1:0] part_index;
    logic                       line_done;
    logic [31:0]                name_hash;
    logic [clth_pkg::PART_W-1:0] part_count;

    modport source (output valid, output char_out, output char_kept, output part_index,
                    output line_done, output name_hash, output part_count, input ready);
    modport sink   (input valid, input char_out, input char_kept, input part_index,
                    input line_done, input name_hash, input part_count, output ready);
endinterface

### src/clth_cfg_if.sv
// Configuration write channel: valid/ready with register index and data.
// Depends on clth_pkg for widths.
interface clth_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [clth_pkg::CFG_IDX_W-1:0]  index;
    logic [clth_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

### src/clth_step.sv
// Per-byte update: next line state and the result for one byte.
// Depends on clth_pkg.
module clth_step (
    input  clth_pkg::line_state_t        cur,
    input  logic [7:0]                   delim,
    input  logic [clth_pkg::PART_W-1:0]  lim,
    input  logic [7:0]                   char_in,
    input  logic                         line_end,
    output clth_pkg::line_state_t        nxt,
    output clth_pkg::result_t            res
);

    logic                        is_crlf;
    logic                        is_delim;
    clth_pkg::line_state_t       upd;
    logic                        kept;
    logic [clth_pkg::PART_W-1:0] pidx;
    logic [clth_pkg::PART_W-1:0] count;

    assign is_crlf  = (char_in == clth_pkg::CHAR_CR) || (char_in == clth_pkg::CHAR_LF);
    assign is_delim = (char_in == delim);

    always_comb
    begin
        upd  = cur;
        kept = 1'b0;
        pidx = '0;
        if (!is_crlf)
        begin
            if (!cur.in_params)
            begin
                if (is_delim)
                begin
                    upd.in_params = 1'b1;
                end
                else
                begin
                    // djb2: h*33 + c
                    upd.running_hash = (cur.running_hash << clth_pkg::HASH_SHIFT)
                                     + cur.running_hash + {24'd0, char_in};
                    kept = 1'b1;
                end
            end
            else if (cur.parts_found < lim)
            begin
                kept          = 1'b1;
                pidx          = cur.parts_found + 1'b1;
                upd.part_open = 1'b1;
                if (is_delim)
                begin
                    // delimiter closes its own part
                    upd.parts_found = cur.parts_found + 1'b1;
                    upd.part_open   = 1'b0;
                end
            end
        end
    end

    // open trailing part counts at end of line
    always_comb
    begin
        count = upd.parts_found;
        if (upd.in_params && upd.part_open && (upd.parts_found < lim))
        begin
            count = upd.parts_found + 1'b1;
        end
    end

    always_comb
    begin
        res.char_out   = char_in;
        res.char_kept  = kept;
        res.part_index = pidx;
        res.line_done  = line_end;
        res.name_hash  = line_end ? upd.running_hash : 32'd0;
        res.part_count = line_end ? count : '0;
        nxt            = line_end ? clth_pkg::LINE_CLEAR : upd;
    end

endmodule

### src/command_line_tokenizer_hash.sv
// Top level of the command line tokenizer with djb2 name hash.
// Depends on clth_pkg, the clth_*_if interfaces, clth_step and the assertion header.
//
// Takes a command line one byte per transfer on cmd_in, line_end flagging the
// final byte, and returns one result per byte on res_out. CR and LF are passed
// through but never kept or hashed. Bytes up to the first delimiter form the
// name and feed a 32-bit wrapping djb2 hash (seed 5381); the first delimiter
// itself is dropped. Later bytes are tagged with a parameter part number from
// 1, each delimiter belonging to the part it closes, until part_limit parts
// are counted (0 acts as 1, values above MAX_PARTS act as MAX_PARTS); bytes
// after that are not kept. The result for the final byte carries the name hash
// and the part count, with an unfinished part counted, and the line state is
// cleared ready for the next line. Throughput is one byte per clock while the
// skid register is empty: the whole per-byte update is one add-and-compare
// step between the line state registers and the result register. A two-entry
// output buffer (result register plus skid register) lets input transfers
// continue while res_out is stalled; cmd_in ready falls only once both
// entries hold results. Configuration writes on cfg are always taken and
// are meant for idle periods between lines.
`include "command_line_tokenizer_hash_assert.svh"

module command_line_tokenizer_hash #(
    parameter int MAX_PARTS = 8
) (
    input  logic       clk,
    input  logic       rst_n,
    clth_cfg_if.sink   cfg,
    clth_in_if.sink    cmd_in,
    clth_out_if.source res_out
);

    localparam logic [clth_pkg::PART_W-1:0] MAX_PARTS_W = clth_pkg::PART_W'(MAX_PARTS);

    // Configuration registers
    logic [7:0]                  delimiter_char_reg;
    logic [clth_pkg::PART_W-1:0] part_limit_reg;
    logic [clth_pkg::PART_W-1:0] eff_limit;

    // Line state
    clth_pkg::line_state_t line_reg;
    clth_pkg::line_state_t line_next;

    // Output buffer
    clth_pkg::result_t step_res;
    clth_pkg::result_t out_data_reg;
    clth_pkg::result_t skid_data_reg;
    logic              out_valid_reg;
    logic              skid_valid_reg;

    logic in_xfer;
    logic out_xfer;

    assign cfg.ready    = 1'b1;
    assign cmd_in.ready = !skid_valid_reg;
    assign in_xfer      = cmd_in.valid && cmd_in.ready;
    assign out_xfer     = out_valid_reg && res_out.ready;

    // Clamp the part limit to 1..MAX_PARTS
    always_comb
    begin
        if (part_limit_reg == '0)
        begin
            eff_limit = clth_pkg::PART_W'(1);
        end
        else if (part_limit_reg > MAX_PARTS_W)
        begin
            eff_limit = MAX_PARTS_W;
        end
        else
        begin
            eff_limit = part_limit_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            delimiter_char_reg <= clth_pkg::DELIM_RESET;
            part_limit_reg     <= clth_pkg::LIMIT_RESET;
        end
        else if (cfg.valid && cfg.ready)
        begin
            unique case (cfg.index)
                clth_pkg::REG_DELIMITER:  delimiter_char_reg <= cfg.data;
                clth_pkg::REG_PART_LIMIT: part_limit_reg <= cfg.data[clth_pkg::PART_W-1:0];
                default: ;
            endcase
        end
    end

    clth_step u_step (
        .cur      (line_reg),
        .delim    (delimiter_char_reg),
        .lim      (eff_limit),
        .char_in  (cmd_in.char_in),
        .line_end (cmd_in.line_end),
        .nxt      (line_next),
        .res      (step_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_reg <= clth_pkg::LINE_CLEAR;
        end
        else if (in_xfer)
        begin
            line_reg <= line_next;
        end
    end

    // Result register refills from the skid entry first, keeping order
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (!out_valid_reg || out_xfer)
        begin
            if (skid_valid_reg)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
            else
            begin
                out_valid_reg <= in_xfer;
            end
        end
        else if (in_xfer)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!out_valid_reg || out_xfer)
        begin
            out_data_reg <= skid_valid_reg ? skid_data_reg : step_res;
        end
        if (out_valid_reg && !out_xfer && in_xfer)
        begin
            skid_data_reg <= step_res;
        end
    end

    assign res_out.valid      = out_valid_reg;
    assign res_out.char_out   = out_data_reg.char_out;
    assign res_out.char_kept  = out_data_reg.char_kept;
    assign res_out.part_index = out_data_reg.part_index;
    assign res_out.line_done  = out_data_reg.line_done;
    assign res_out.name_hash  = out_data_reg.name_hash;
    assign res_out.part_count = out_data_reg.part_count;

    // Skid entry never holds a result without the result register being full
    `CLTH_ASSERT_IMPL(a_skid_order, clk, rst_n, skid_valid_reg, out_valid_reg)
    // A final byte leaves the line state cleared
    `CLTH_ASSERT_NEXT(a_line_clear, clk, rst_n, in_xfer && cmd_in.line_end,
                      line_reg == clth_pkg::LINE_CLEAR)
    // Part counter never exceeds MAX_PARTS
    `CLTH_ASSERT_IMPL(a_parts_bound, clk, rst_n, 1'b1, line_reg.parts_found <= MAX_PARTS_W)
    // A dropped byte carries no part number
    `CLTH_ASSERT_IMPL(a_drop_index, clk, rst_n, out_valid_reg && !out_data_reg.char_kept,
                      out_data_reg.part_index == '0)

endmodule
